/* hw/rtl/smooth_consecutive_pair_finder_defines.svh */
// Assertion macros for the smooth consecutive pair finder.
// Included by the top level; needs clk and rst_n in scope at the point of use.
`ifndef SMOOTH_CONSECUTIVE_PAIR_FINDER_DEFINES_SVH
`define SMOOTH_CONSECUTIVE_PAIR_FINDER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define SCPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define SCPF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCPF_ASSERT(lbl, prop, msg)
`define SCPF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hw/rtl/scpf_pkg.sv */
// Shared constants for the smooth consecutive pair finder: prime table,
// default sizes, field widths and register indexes. No dependencies.
package scpf_pkg;

    localparam int MAX_PRIMES_DEF = 18;
    localparam int VALUE_BITS_DEF = 46;
    localparam int TABLE_SIZE     = 32;
    localparam int PRIME_W        = 8;
    localparam int CFG_W          = 5;
    localparam int CFG_IDX_W      = 1;
    localparam int PIDX_W         = 5;
    localparam int EXP_W          = 7;

    localparam logic [CFG_IDX_W-1:0] REG_PRIME_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LIMIT  = 1'b1;

    localparam logic [PRIME_W-1:0] PRIME_TABLE [TABLE_SIZE] = '{
        8'd2,  8'd3,  8'd5,  8'd7,  8'd11, 8'd13, 8'd17, 8'd19,
        8'd23, 8'd29, 8'd31, 8'd37, 8'd41, 8'd43, 8'd47, 8'd53,
        8'd59, 8'd61, 8'd67, 8'd71, 8'd73, 8'd79, 8'd83, 8'd89,
        8'd97, 8'd101, 8'd103, 8'd107, 8'd109, 8'd113, 8'd127, 8'd131
    };

endpackage

/* hw/rtl/scpf_cell.sv */
// One cell of the factoring chain: strips its prime from the value handed in,
// counts the exponent, and hands the cofactor to the next cell. Uses scpf_pkg.
module scpf_cell #(
    parameter int VALUE_BITS = scpf_pkg::VALUE_BITS_DEF,
    parameter logic [scpf_pkg::PRIME_W-1:0] PRIME = 8'd2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [VALUE_BITS-1:0]         in_value,
    output logic                          out_valid,
    output logic [VALUE_BITS-1:0]         out_value,
    output logic [$clog2(VALUE_BITS)-1:0] exp_count
);
    import scpf_pkg::*;

    localparam int EW = $clog2(VALUE_BITS);
    localparam int LW = (VALUE_BITS + 1) / 2;
    localparam int HW = VALUE_BITS - LW;
    localparam int PW = 2 * LW;
    localparam bit IS_TWO = (PRIME == PRIME_W'(2));

    // Inverse of an odd number modulo 2^64, Newton iteration from 3 good bits.
    function automatic logic [63:0] inv_mod(input logic [63:0] p);
        logic [63:0] x;
        x = p;
        for (int i = 0; i < 6; i++)
            x = x * (64'd2 - p * x);
        return x;
    endfunction

    localparam logic [63:0]           INV64    = inv_mod(64'(PRIME));
    localparam logic [VALUE_BITS-1:0] INV      = INV64[VALUE_BITS-1:0];
    localparam logic [LW-1:0]         INV_LO   = INV[LW-1:0];
    localparam logic [HW-1:0]         INV_HI   = INV[VALUE_BITS-1:LW];
    localparam logic [VALUE_BITS-1:0] ALL_ONES = '1;
    localparam logic [VALUE_BITS-1:0] Q_LIMIT  = ALL_ONES / VALUE_BITS'(PRIME);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_MUL  = 3'b010,
        C_CHK  = 3'b100
    } cell_state_t;

    cell_state_t             state_reg;
    logic                    done_reg;
    logic [VALUE_BITS-1:0]   value_reg;
    logic [EW-1:0]           exp_reg;
    logic [VALUE_BITS-1:0]   ll_reg;
    logic [HW-1:0]           cross_reg;

    logic [LW-1:0]           v_lo;
    logic [HW-1:0]           v_hi;
    logic [PW-1:0]           p_ll;
    logic [VALUE_BITS-1:0]   p_lh;
    logic [VALUE_BITS-1:0]   p_hl;
    logic [VALUE_BITS-1:0]   quot;
    logic                    divides;

    // Exact division by the prime: multiply by its inverse modulo 2^VALUE_BITS
    // in two halves; the value divides when the product is at most
    // all-ones / prime, and the product is then the quotient; prime two uses a shift.
    always_comb
    begin
        v_lo = value_reg[LW-1:0];
        v_hi = value_reg[VALUE_BITS-1:LW];
        p_ll = PW'(v_lo) * PW'(INV_LO);
        p_lh = VALUE_BITS'(v_lo) * VALUE_BITS'(INV_HI);
        p_hl = VALUE_BITS'(v_hi) * VALUE_BITS'(INV_LO);
        if (IS_TWO)
        begin
            quot    = {1'b0, value_reg[VALUE_BITS-1:1]};
            divides = !value_reg[0];
        end
        else
        begin
            quot    = ll_reg + {cross_reg, {LW{1'b0}}};
            divides = (quot <= Q_LIMIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (in_valid)
                    begin
                        value_reg <= in_value;
                        exp_reg   <= '0;
                        // zero and one have nothing to strip
                        if (in_value[VALUE_BITS-1:1] == '0)
                            done_reg <= 1'b1;
                        else
                            state_reg <= C_MUL;
                    end
                end
                C_MUL:
                begin
                    ll_reg    <= VALUE_BITS'(p_ll);
                    cross_reg <= HW'(p_lh) + HW'(p_hl);
                    state_reg <= C_CHK;
                end
                C_CHK:
                begin
                    if (divides)
                    begin
                        // divides: keep the quotient and try again
                        value_reg <= quot;
                        exp_reg   <= exp_reg + 1'b1;
                        if (quot == VALUE_BITS'(1))
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= C_IDLE;
                        end
                        else
                            state_reg <= C_MUL;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                end
                default:
                    state_reg <= C_IDLE;
            endcase
        end
    end

    assign out_valid = done_reg;
    assign out_value = value_reg;
    assign exp_count = exp_reg;

endmodule

/* hw/rtl/smooth_consecutive_pair_finder.sv */
// Smooth consecutive pair finder, top level: handshake, config, cell chain,
// pair test and result sequencer. Uses scpf_pkg, scpf_cell and the defines header.
//
// Each candidate beat runs down a chain of MAX_PRIMES cells, one per table
// prime. A cell strips its prime by exact division (multiply by the prime's
// inverse, then test the product; a multiply and a check state per trial)
// and repeats until a trial fails, so the time from one accepted candidate
// to the next grows with the sum of its exponents: the trial divisions in
// the cells set this. A cell whose input is zero or one passes it with no
// trial, and a cell that reaches one skips its final failing trial.
// The candidate is smooth when the cofactor leaving cell prime_count-1 is one.
// A pair (both candidates smooth, the previous exactly one less, modulo
// 2^VALUE_BITS) whose count of primes dividing neither value is at most
// the zero limit produces prime_count result beats, one a cycle while the
// consumer takes them, with last set on the final one.
// A new candidate is taken once all beats of the previous one are in the
// output register. prime_count 0 acts as 1 and values above MAX_PRIMES
// saturate. Write the configuration only while the block is idle. No
// clearing pass after reset.
`include "smooth_consecutive_pair_finder_defines.svh"
module smooth_consecutive_pair_finder #(
    parameter int MAX_PRIMES = scpf_pkg::MAX_PRIMES_DEF,
    parameter int VALUE_BITS = scpf_pkg::VALUE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [scpf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [scpf_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                   candidate_valid,
    output logic                                   candidate_ready,
    input  logic [VALUE_BITS-1:0]                  candidate,
    output logic                                   result_valid,
    input  logic                                   result_ready,
    output logic [VALUE_BITS-1:0]                  numerator,
    output logic [scpf_pkg::PIDX_W-1:0]            prime_index,
    output logic signed [scpf_pkg::EXP_W-1:0]      exponent,
    output logic                                   last
);
    import scpf_pkg::*;

    localparam int EW = $clog2(VALUE_BITS);
    localparam int KW = $clog2(MAX_PRIMES + 1);
    localparam int IW = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_EMIT = 3'b100
    } top_state_t;

    // config registers
    logic [CFG_W-1:0] prime_count_reg;
    logic [CFG_W-1:0] zero_limit_reg;
    logic [KW-1:0]    k_act;

    top_state_t             state_reg;
    logic [VALUE_BITS-1:0]  cand_reg;
    logic                   start_reg;
    logic [VALUE_BITS-1:0]  prev_value_reg;
    logic                   prev_smooth_reg;
    logic [EW-1:0]          prev_exp_reg [MAX_PRIMES];
    logic signed [EXP_W-1:0] diff_reg    [MAX_PRIMES];
    logic [IW-1:0]          emit_idx_reg;

    logic                   out_valid_reg;
    logic [VALUE_BITS-1:0]  out_num_reg;
    logic [PIDX_W-1:0]      out_idx_reg;
    logic signed [EXP_W-1:0] out_exp_reg;
    logic                   out_last_reg;

    // chain wiring
    logic                   link_valid [MAX_PRIMES+1];
    logic [VALUE_BITS-1:0]  link_value [MAX_PRIMES+1];
    logic [VALUE_BITS-1:0]  cell_value [MAX_PRIMES];
    logic [EW-1:0]          cell_exp   [MAX_PRIMES];

    logic                   chain_done;
    logic                   smooth;
    logic                   follows;
    logic [KW-1:0]          zero_cnt;
    logic                   report;
    logic [IW-1:0]          k_last;
    logic                   slot_free;

    // Clamp prime_count into 1..MAX_PRIMES.
    always_comb
    begin
        if (prime_count_reg == '0)
            k_act = KW'(1);
        else if (6'(prime_count_reg) > 6'(MAX_PRIMES))
            k_act = KW'(MAX_PRIMES);
        else
            k_act = KW'(prime_count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_count_reg <= CFG_W'(18);
            zero_limit_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PRIME_COUNT: prime_count_reg <= cfg_data;
                REG_ZERO_LIMIT:  zero_limit_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Cell chain: cell i hands its cofactor to cell i+1.
    assign link_valid[0] = start_reg;
    assign link_value[0] = cand_reg;

    for (genvar i = 0; i < MAX_PRIMES; i++)
    begin : g_cell
        scpf_cell #(
            .VALUE_BITS (VALUE_BITS),
            .PRIME      (PRIME_TABLE[i])
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (link_valid[i]),
            .in_value  (link_value[i]),
            .out_valid (link_valid[i+1]),
            .out_value (link_value[i+1]),
            .exp_count (cell_exp[i])
        );
        assign cell_value[i] = link_value[i+1];
    end

    assign chain_done = link_valid[MAX_PRIMES];
    assign k_last     = IW'(k_act - 1'b1);

    // Pair test, evaluated when the chain finishes.
    always_comb
    begin
        smooth   = (cell_value[k_last] == VALUE_BITS'(1));
        follows  = (VALUE_BITS'(prev_value_reg + 1'b1) == cand_reg);
        zero_cnt = '0;
        for (int i = 0; i < MAX_PRIMES; i++)
        begin
            if ((KW'(i) < k_act) && (cell_exp[i] == '0) && (prev_exp_reg[i] == '0))
                zero_cnt = zero_cnt + 1'b1;
        end
        report = smooth && prev_smooth_reg && follows
                 && (6'(zero_cnt) <= 6'(zero_limit_reg));
    end

    assign slot_free       = !out_valid_reg || result_ready;
    assign candidate_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            start_reg       <= 1'b0;
            prev_value_reg  <= '0;
            prev_smooth_reg <= 1'b0;
            emit_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < MAX_PRIMES; i++)
                prev_exp_reg[i] <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_valid_reg && result_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (candidate_valid)
                    begin
                        cand_reg  <= candidate;
                        start_reg <= 1'b1;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (chain_done)
                    begin
                        // latch differences, then advance the stored state
                        for (int i = 0; i < MAX_PRIMES; i++)
                        begin
                            diff_reg[i] <= EXP_W'(cell_exp[i]) - EXP_W'(prev_exp_reg[i]);
                            prev_exp_reg[i] <= cell_exp[i];
                        end
                        prev_value_reg  <= cand_reg;
                        prev_smooth_reg <= smooth;
                        emit_idx_reg    <= '0;
                        state_reg       <= report ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_num_reg   <= cand_reg;
                        out_idx_reg   <= PIDX_W'(emit_idx_reg);
                        out_exp_reg   <= diff_reg[emit_idx_reg];
                        out_last_reg  <= (emit_idx_reg == k_last);
                        emit_idx_reg  <= emit_idx_reg + 1'b1;
                        if (emit_idx_reg == k_last)
                            state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign numerator    = out_num_reg;
    assign prime_index  = out_idx_reg;
    assign exponent     = out_exp_reg;
    assign last         = out_last_reg;

    `SCPF_ASSERT(a_accept_starts_chain, candidate_valid && candidate_ready |=> start_reg && state_reg == S_RUN, "accepted beat did not start the chain")
    `SCPF_ASSERT(a_chain_done_in_run, chain_done |-> state_reg == S_RUN, "chain finished outside run state")
    `SCPF_ASSERT(a_emit_index_range, state_reg == S_EMIT |-> KW'(emit_idx_reg) < k_act, "emit index past prime count")
    `SCPF_ASSERT_ALWAYS(a_no_start_in_reset, !rst_n |-> !start_reg, "chain start during reset")

endmodule
